FILE: hw/rtl/fcw_pkg.sv
// ----------------------------------------------------------------------------
// fcw_pkg
// Shared constants and types for the FAT cluster chain walker.
// ----------------------------------------------------------------------------
package fcw_pkg;

  localparam int FCW_TABLE_BYTES = 8192;
  localparam int FCW_MAX_CHAIN   = 64;

  // wide enough for any byte offset of a 16-bit cluster and for the table size
  localparam int OFS_W = 18;

  localparam logic [15:0] END12 = 16'h0FF8;
  localparam logic [15:0] END16 = 16'hFFF8;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_WALK  = 1'b1;

  localparam logic CFG_FAT_MODE   = 1'b0;
  localparam logic CFG_STEP_LIMIT = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_LIMIT  = 2'd2;
  localparam logic [1:0] ST_RANGE  = 2'd3;

  typedef struct packed {
    logic       fat_mode;
    logic [6:0] step_limit;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic [OFS_W-1:0] addr;
    logic [7:0]       data;
  } wr_req_t;

  typedef struct packed {
    logic [OFS_W-1:0] addr_lo;
    logic [OFS_W-1:0] addr_hi;
  } rd_req_t;

  typedef struct packed {
    logic       busy;
    logic [6:0] count;
  } walk_stat_t;

endpackage

FILE: hw/rtl/fcw_table.sv
// ----------------------------------------------------------------------------
// fcw_table
// Byte-wide table memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module fcw_table #(
  parameter int TABLE_BYTES = fcw_pkg::FCW_TABLE_BYTES
) (
  input  logic             clk,
  input  fcw_pkg::wr_req_t wr,
  input  fcw_pkg::rd_req_t rd,
  output logic [7:0]       rd_lo,
  output logic [7:0]       rd_hi
);
  import fcw_pkg::*;

  localparam int AW = $clog2(TABLE_BYTES);

  logic [7:0] mem [TABLE_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    rd_lo <= mem[rd.addr_lo[AW-1:0]];
    rd_hi <= mem[rd.addr_hi[AW-1:0]];
  end

endmodule

FILE: hw/rtl/fcw_walk.sv
// ----------------------------------------------------------------------------
// fcw_walk
// Sequencer: takes items, issues table writes and entry reads, decodes links
// and drives the result register.
// ----------------------------------------------------------------------------
module fcw_walk #(
  parameter int TABLE_BYTES = fcw_pkg::FCW_TABLE_BYTES,
  parameter int MAX_CHAIN   = fcw_pkg::FCW_MAX_CHAIN
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fcw_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_kind,
  input  logic [12:0]         in_addr,
  input  logic [7:0]          in_byte,
  input  logic [15:0]         in_start,
  output fcw_pkg::wr_req_t    wr,
  output fcw_pkg::rd_req_t    rd,
  input  logic [7:0]          rd_lo,
  input  logic [7:0]          rd_hi,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         out_cluster,
  output logic                out_last,
  output logic [1:0]          out_status,
  output fcw_pkg::walk_stat_t stat
);
  import fcw_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;

  localparam logic [OFS_W-1:0] TBL_END = OFS_W'(TABLE_BYTES);

  logic [1:0]  state_r, state_nxt;
  logic [15:0] cur_r, cur_nxt;
  logic [6:0]  n_r, n_nxt;
  logic        rej_r, rej_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_cluster_r, out_cluster_nxt;
  logic        out_last_r, out_last_nxt;
  logic [1:0]  out_status_r, out_status_nxt;

  logic [OFS_W-1:0] cur_ext, off, off1;
  logic             in_range;
  logic [15:0]      next_link;
  logic             is_end;
  logic [6:0]       lim;
  logic             take;

  assign in_ready = (state_r == S_IDLE);
  assign take     = in_valid && in_ready;

  assign wr.en   = take && (in_kind == KIND_WRITE) && ({5'd0, in_addr} < TBL_END);
  assign wr.addr = {5'd0, in_addr};
  assign wr.data = in_byte;

  assign cur_ext  = {2'd0, cur_r};
  assign off      = cfg.fat_mode ? (cur_ext << 1) : (cur_ext + (cur_ext >> 1));
  assign off1     = off + OFS_W'(1);
  assign in_range = off1 < TBL_END;

  assign rd.addr_lo = off;
  assign rd.addr_hi = off1;

  always_comb begin
    if (cfg.fat_mode) begin
      next_link = {rd_hi, rd_lo};
      is_end    = next_link >= END16;
    end else begin
      if (cur_r[0]) begin
        next_link = {4'd0, rd_hi, rd_lo[7:4]};
      end else begin
        next_link = {4'd0, rd_hi[3:0], rd_lo};
      end
      is_end = next_link >= END12;
    end
  end

  always_comb begin
    if (cfg.step_limit == 7'd0) begin
      lim = 7'd1;
    end else if (cfg.step_limit > 7'(MAX_CHAIN)) begin
      lim = 7'(MAX_CHAIN);
    end else begin
      lim = cfg.step_limit;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cur_nxt         = cur_r;
    n_nxt           = n_r;
    rej_nxt         = rej_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_cluster_nxt = out_cluster_r;
    out_last_nxt    = out_last_r;
    out_status_nxt  = out_status_r;
    case (state_r)
      S_IDLE: begin
        if (take && (in_kind == KIND_WALK)) begin
          cur_nxt   = in_start;
          n_nxt     = 7'd1;
          rej_nxt   = !cfg.fat_mode && (in_start < 16'd2);
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_cluster_nxt = cur_r;
          out_last_nxt    = 1'b1;
          state_nxt       = S_IDLE;
          if (rej_r) begin
            out_status_nxt = ST_REJECT;
          end else if (!in_range) begin
            out_status_nxt = ST_RANGE;
          end else if (is_end) begin
            out_status_nxt = ST_OK;
          end else if (n_r >= lim) begin
            out_status_nxt = ST_LIMIT;
          end else begin
            out_status_nxt = ST_OK;
            out_last_nxt   = 1'b0;
            cur_nxt        = next_link;
            n_nxt          = n_r + 7'd1;
            state_nxt      = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      n_r         <= 7'd0;
      rej_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      rej_r       <= rej_nxt;
    end
    cur_r         <= cur_nxt;
    out_cluster_r <= out_cluster_nxt;
    out_last_r    <= out_last_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_cluster = out_cluster_r;
  assign out_last    = out_last_r;
  assign out_status  = out_status_r;

  assign stat.busy  = (state_r != S_IDLE);
  assign stat.count = n_r;

endmodule

FILE: hw/rtl/fat_cluster_chain_walk.sv
// ----------------------------------------------------------------------------
// fat_cluster_chain_walk
// FAT12/FAT16 cluster chain walker over an on-chip byte table.
// ----------------------------------------------------------------------------
// Write beats (tuser = 0) store one table byte. A walk beat (tuser = 1) emits
// the start cluster and each following link, one result beat per cluster,
// with tlast on the final one and its status in tuser. Each link passes
// through S_RD, which presents both entry byte addresses to the dual-read
// table memory, and then S_EVAL, which decodes the registered bytes and waits
// while an earlier result beat is still pending. The input is taken only
// between walks; a pending result beat does not block the next input beat.
// The table has no reset; walks must read only written bytes. Configuration
// writes are accepted in every cycle.
module fat_cluster_chain_walk #(
  parameter int TABLE_BYTES = fcw_pkg::FCW_TABLE_BYTES,
  parameter int MAX_CHAIN   = fcw_pkg::FCW_MAX_CHAIN
) (
  input  logic        clk,
  input  logic        rst_n,
  // config: cfg_data[0] fat_mode, cfg_data[6:0] step_limit
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [12:0] byte_address, [20:13] byte_value, [36:21] start_cluster
  input  logic [39:0] in_tdata,
  // [0] kind
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] cluster
  output logic [15:0] out_tdata,
  output logic        out_tlast,
  // [1:0] status
  output logic [1:0]  out_tuser
);
  import fcw_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  wr_req_t    wr;
  rd_req_t    rd;
  logic [7:0] rd_lo, rd_hi;
  walk_stat_t stat;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FAT_MODE:   cfg_nxt.fat_mode   = cfg_data[0];
        CFG_STEP_LIMIT: cfg_nxt.step_limit = cfg_data;
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fat_mode   <= 1'b0;
      cfg_r.step_limit <= 7'd64;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fcw_walk #(
    .TABLE_BYTES(TABLE_BYTES),
    .MAX_CHAIN  (MAX_CHAIN)
  ) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_kind    (in_tuser),
    .in_addr    (in_tdata[12:0]),
    .in_byte    (in_tdata[20:13]),
    .in_start   (in_tdata[36:21]),
    .wr         (wr),
    .rd         (rd),
    .rd_lo      (rd_lo),
    .rd_hi      (rd_hi),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_cluster(out_tdata),
    .out_last   (out_tlast),
    .out_status (out_tuser),
    .stat       (stat)
  );

  fcw_table #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_table (
    .clk  (clk),
    .wr   (wr),
    .rd   (rd),
    .rd_lo(rd_lo),
    .rd_hi(rd_hi)
  );

  a_status_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> out_tlast)
    else $error("nonzero status on a beat without tlast");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> (stat.count >= 7'd1) && (stat.count <= 7'(MAX_CHAIN)))
    else $error("walk count out of bounds");

  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stat.busy) |-> $past(in_tvalid && in_tready && (in_tuser == KIND_WALK)))
    else $error("walk started without a walk beat");

endmodule

FILE: tb/sv/tb_fat_cluster_chain_walk.sv
// ----------------------------------------------------------------------------
// tb_fat_cluster_chain_walk
// Self-checking bench for the FAT12/FAT16 cluster chain walker.
// ----------------------------------------------------------------------------
// A short scripted sequence covers rejected starts, entries at and past the
// table end, end markers, self loops under the step limit and the limit
// extremes. Random phases then build chains in the table with random content
// and walk them under several mode and limit settings, mixed with stray
// writes and walks from arbitrary clusters. A shadow table and chain tracer
// predict all but scripted fixed-status beats; both sides idle at random,
// and the result side once holds off long so the walker backs up to its input.
// ----------------------------------------------------------------------------
module tb_fat_cluster_chain_walk;
  import fcw_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 150;
  localparam int N_PHASES     = 8;
  localparam int PHASE_ITEMS  = 57;

  typedef struct packed {
    logic        kind;
    logic [12:0] addr;
    logic [7:0]  val;
    logic [15:0] start;
  } fat_item_t;

  typedef struct packed {
    logic [15:0] cluster;
    logic        last;
    logic [1:0]  status;
  } chain_beat_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_WALK, ROW_CFG} row_op_t;

  typedef struct {
    row_op_t     op;
    logic [15:0] a;
    logic [7:0]  b;
    bit          typed;
    logic [1:0]  st;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [6:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;

  bit [7:0]    fat_mem [FCW_TABLE_BYTES];
  bit          byte_known [FCW_TABLE_BYTES];
  logic        fat16_sel;
  logic [6:0]  link_cap;
  chain_beat_t pending_links[$];
  logic [15:0] known_q[$];
  script_row_t script[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          quiet_cycles = 0;
  bit          src_calm = 1'b0;
  bit          sink_hold = 1'b0;
  logic        phase_mode [N_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  logic [6:0]  phase_limit [N_PHASES] = '{7'd64, 7'd64, 7'd1, 7'd0, 7'd127, 7'd0, 7'd0, 7'd1};

  fat_cluster_chain_walk uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int entry_offset(logic [15:0] c);
    return fat16_sel ? int'(c) * 2 : (int'(c) * 3) / 2;
  endfunction

  function automatic logic [15:0] decode_link(logic [15:0] c, logic [7:0] lo, logic [7:0] hi);
    if (fat16_sel) return {hi, lo};
    if (!c[0]) return {4'h0, hi[3:0], lo};
    return {4'h0, hi, lo[7:4]};
  endfunction

  function automatic int eff_limit();
    int l;
    l = int'(link_cap);
    if (l < 1) l = 1;
    if (l > FCW_MAX_CHAIN) l = FCW_MAX_CHAIN;
    return l;
  endfunction

  // trace one accepted beat through the shadow table
  function automatic void chain_predict(fat_item_t it);
    logic [15:0] cur;
    logic [15:0] nxt;
    logic [15:0] endm;
    int          off;
    int          n;
    if (it.kind == KIND_WRITE) begin
      fat_mem[it.addr] = it.val;
      return;
    end
    cur = it.start;
    if (!fat16_sel && cur < 2) begin
      pending_links.push_back('{cur, 1'b1, ST_REJECT});
      return;
    end
    endm = fat16_sel ? END16 : END12;
    n = 1;
    forever begin
      off = entry_offset(cur);
      if (off + 1 >= FCW_TABLE_BYTES) begin
        pending_links.push_back('{cur, 1'b1, ST_RANGE});
        return;
      end
      nxt = decode_link(cur, fat_mem[off], fat_mem[off + 1]);
      if (nxt >= endm) begin
        pending_links.push_back('{cur, 1'b1, ST_OK});
        return;
      end
      if (n >= eff_limit()) begin
        pending_links.push_back('{cur, 1'b1, ST_LIMIT});
        return;
      end
      pending_links.push_back('{cur, 1'b0, ST_OK});
      cur = nxt;
      n++;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  task automatic send_item(input fat_item_t it, input bit typed, input chain_beat_t want);
    int gap;
    gap = (src_calm || $urandom_range(0, 99) < 45) ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, it.start, it.val, it.addr};
    in_tuser  <= it.kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (typed) pending_links.push_back(want);
    else chain_predict(it);
  endtask

  task automatic put_byte(input logic [12:0] addr, input logic [7:0] val);
    byte_known[addr] = 1'b1;
    send_item('{KIND_WRITE, addr, val, 16'd0}, 1'b0, '0);
  endtask

  // fill in any missing entries along the chain, then walk it
  task automatic walk_chain(input logic [15:0] start);
    logic [15:0] cur;
    logic [15:0] nxt;
    logic [15:0] lnk;
    logic [15:0] endm;
    int          off;
    int          n;
    int          r;
    cur = start;
    n = 1;
    endm = fat16_sel ? END16 : END12;
    if (fat16_sel || start >= 2) begin
      forever begin
        off = entry_offset(cur);
        if (off + 1 >= FCW_TABLE_BYTES) break;
        if (!byte_known[off] || !byte_known[off + 1]) begin
          r = $urandom_range(0, 99);
          if (r < 12)
            lnk = fat16_sel ? 16'($urandom_range(16'hFFF8, 16'hFFFF))
                            : 16'($urandom_range(12'hFF8, 12'hFFF));
          else if (r < 35 && known_q.size() > 0)
            lnk = known_q[$urandom_range(0, known_q.size() - 1)];
          else if (r < 40 && fat16_sel)
            lnk = 16'($urandom_range(4096, 16'hFFF7));
          else
            lnk = 16'($urandom_range(0, fat16_sel ? 4095 : 2000));
          if (fat16_sel) begin
            put_byte(13'(off), lnk[7:0]);
            put_byte(13'(off + 1), lnk[15:8]);
          end else if (!cur[0]) begin
            put_byte(13'(off), lnk[7:0]);
            put_byte(13'(off + 1), {fat_mem[off + 1][7:4], lnk[11:8]});
          end else begin
            put_byte(13'(off), {lnk[3:0], fat_mem[off][3:0]});
            put_byte(13'(off + 1), lnk[11:4]);
          end
        end
        nxt = decode_link(cur, fat_mem[off], fat_mem[off + 1]);
        if (nxt >= endm || n >= eff_limit()) break;
        cur = nxt;
        n++;
      end
      if (entry_offset(start) + 1 < FCW_TABLE_BYTES) known_q.push_back(start);
    end
    send_item('{KIND_WALK, 13'd0, 8'd0, start}, 1'b0, '0);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_links.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic mode, input logic [6:0] limit);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FAT_MODE;
    cfg_data  <= {6'd0, mode};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fat16_sel = mode;
    cfg_index <= CFG_STEP_LIMIT;
    cfg_data  <= limit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    link_cap = limit;
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_row(row_op_t op, logic [15:0] a, logic [7:0] b, bit typed,
                                  logic [1:0] st);
    script.push_back('{op, a, b, typed, st});
  endfunction

  always @(posedge clk) begin : result_monitor
    chain_beat_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_links.size() == 0) begin
        report_mismatch($sformatf("unexpected beat cluster=%h", out_tdata));
      end else begin
        e = pending_links.pop_front();
        if (out_tdata !== e.cluster)
          report_mismatch($sformatf("cluster %h, want %h", out_tdata, e.cluster));
        if (out_tlast !== e.last)
          report_mismatch($sformatf("last %b, want %b at cluster %h", out_tlast, e.last,
                                    e.cluster));
        if (out_tuser !== e.status)
          report_mismatch($sformatf("status %0d, want %0d at cluster %h", out_tuser,
                                    e.status, e.cluster));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : sink_driver
    bit lvl;
    int left;
    int k;
    lvl = 1'b0;
    left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold) begin
        out_tready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        sink_hold = 1'b0;
        lvl = 1'b1;
        left = 20;
        out_tready <= 1'b1;
      end else begin
        if (left == 0) begin
          lvl = !lvl;
          left = lvl ? $urandom_range(1, 40) : idle_len();
        end
        out_tready <= lvl;
        left--;
      end
    end
  end

  initial begin : stimulus
    int p;
    int r;
    int sent0;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    fat16_sel = 1'b0;
    link_cap  = 7'd64;
    phase_limit[5] = 7'($urandom_range(2, 63));
    phase_limit[6] = 7'($urandom_range(65, 126));

    add_row(ROW_WALK,  16'd0,     8'h00, 1, ST_REJECT);
    add_row(ROW_WALK,  16'd1,     8'h00, 1, ST_REJECT);
    add_row(ROW_WALK,  16'hFFFF,  8'h00, 1, ST_RANGE);
    add_row(ROW_WALK,  16'd5461,  8'h00, 1, ST_RANGE);
    add_row(ROW_WRITE, 16'd3,     8'hFF, 0, ST_OK);
    add_row(ROW_WRITE, 16'd4,     8'h2F, 0, ST_OK);
    add_row(ROW_WRITE, 16'd5,     8'h00, 0, ST_OK);
    add_row(ROW_WALK,  16'd2,     8'h00, 0, ST_OK);
    add_row(ROW_WALK,  16'd3,     8'h00, 0, ST_OK);
    add_row(ROW_WRITE, 16'd6,     8'h04, 0, ST_OK);
    add_row(ROW_WRITE, 16'd7,     8'h50, 0, ST_OK);
    add_row(ROW_WRITE, 16'd8,     8'h00, 0, ST_OK);
    add_row(ROW_WALK,  16'd4,     8'h00, 0, ST_OK);
    add_row(ROW_WALK,  16'd5,     8'h00, 0, ST_OK);
    add_row(ROW_CFG,   16'd0,     8'd1,  0, ST_OK);
    add_row(ROW_WALK,  16'd4,     8'h00, 1, ST_LIMIT);
    add_row(ROW_WALK,  16'd2,     8'h00, 1, ST_OK);
    add_row(ROW_CFG,   16'd0,     8'd0,  0, ST_OK);
    add_row(ROW_WALK,  16'd4,     8'h00, 1, ST_LIMIT);
    add_row(ROW_CFG,   16'd1,     8'd127, 0, ST_OK);
    add_row(ROW_WRITE, 16'd0,     8'hF8, 0, ST_OK);
    add_row(ROW_WRITE, 16'd1,     8'hFF, 0, ST_OK);
    add_row(ROW_WALK,  16'd0,     8'h00, 1, ST_OK);
    add_row(ROW_WALK,  16'd4096,  8'h00, 1, ST_RANGE);
    add_row(ROW_WRITE, 16'd8190,  8'hFF, 0, ST_OK);
    add_row(ROW_WRITE, 16'd8191,  8'hFF, 0, ST_OK);
    add_row(ROW_WALK,  16'd4095,  8'h00, 1, ST_OK);
    add_row(ROW_WRITE, 16'd0,     8'hF7, 0, ST_OK);
    add_row(ROW_WALK,  16'd0,     8'h00, 0, ST_OK);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      case (script[i].op)
        ROW_CFG: begin
          settle();
          apply_setting(script[i].a[0], script[i].b[6:0]);
        end
        ROW_WRITE: put_byte(script[i].a[12:0], script[i].b);
        default: send_item('{KIND_WALK, 13'd0, 8'd0, script[i].a}, script[i].typed,
                           '{script[i].a, 1'b1, script[i].st});
      endcase
    end

    for (p = 0; p < N_PHASES; p++) begin
      settle();
      apply_setting(phase_mode[p], phase_limit[p]);
      src_calm = (p % 3 == 2);
      if (p == 1) sink_hold = 1'b1;
      sent0 = items_sent;
      while (items_sent - sent0 < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 15)
          put_byte(13'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)));
        else if (r < 30)
          walk_chain(16'($urandom_range(0, 65535)));
        else if (r < 55 && known_q.size() > 0)
          walk_chain(known_q[$urandom_range(0, known_q.size() - 1)]);
        else
          walk_chain(16'($urandom_range(0, fat16_sel ? 4095 : 2000)));
      end
    end

    settle();
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

FILE: fat_cluster_chain_walk.f
hw/rtl/fcw_pkg.sv
hw/rtl/fcw_table.sv
hw/rtl/fcw_walk.sv
hw/rtl/fat_cluster_chain_walk.sv
tb/sv/tb_fat_cluster_chain_walk.sv
